// ===== src/rspt_pkg.sv =====
// shared types and constants for the retention safe point tracker
`timescale 1ns / 1ps
package rspt_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int IDX_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int TIME_W     = 64;
  localparam int TS_W       = 64;
  localparam int RET_W      = 32;

  localparam logic [RET_W-1:0] RETENTION_RESET = RET_W'(600000);

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [TS_W-1:0]   ts;
  } sample_t;

  // chain control from the sequencer
  typedef struct packed {
    logic             shift;
    logic             load;
    logic [IDX_W-1:0] load_idx;
  } chain_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } ctrl_status_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

// ===== src/rspt_cell.sv =====
// one sample cell of the shifting sample chain
`timescale 1ns / 1ps
module rspt_cell (
  input  logic             clk,
  input  logic             shift,
  input  logic             load,
  input  rspt_pkg::sample_t load_data,
  input  rspt_pkg::sample_t neighbor,
  output rspt_pkg::sample_t data
);
  import rspt_pkg::*;

  sample_t data_r;
  sample_t data_nxt;

  // load wins over shift so a push and a drop can share a cycle
  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = load_data;
    end else if (shift) begin
      data_nxt = neighbor;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== src/rspt_ctrl.sv =====
// sequencer: push, head expiry scan, retention register and result registers
`timescale 1ns / 1ps
module rspt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rspt_pkg::TIME_W-1:0]   in_now_ms,
  input  logic                          cfg_we,
  input  logic [rspt_pkg::RET_W-1:0]    cfg_retention_ms,
  input  rspt_pkg::sample_t             head,
  output logic                          busy,
  output rspt_pkg::chain_ctrl_t         chain,
  output rspt_pkg::ctrl_status_t        status,
  output logic                          out_valid,
  output logic                          out_collect,
  output logic [rspt_pkg::TS_W-1:0]     out_safe_point_ts,
  output logic                          out_sample_dropped
);
  import rspt_pkg::*;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [RET_W-1:0]  retention_r;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TS_W-1:0]   safe_r, safe_nxt;
  logic              dropped_r, dropped_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [TS_W-1:0]   osafe_r, osafe_nxt;
  logic              odrop_r, odrop_nxt;

  logic              accept;
  logic              full;
  logic [CNT_W-1:0]  cnt_after_drop;
  logic [TIME_W:0]   expiry_sum;
  logic              expired;
  logic              pop;

  assign accept         = (state_r == ST_IDLE) && start;
  assign full           = (count_r == CNT_FULL);
  assign cnt_after_drop = full ? (CNT_FULL - CNT_W'(1)) : count_r;

  // saturating sum: on carry the bound is all ones, reached only by an all-ones now
  assign expiry_sum = {1'b0, head.time_ms} + {{(TIME_W+1-RET_W){1'b0}}, retention_r};
  assign expired    = expiry_sum[TIME_W] ? (&now_r)
                                         : (expiry_sum[TIME_W-1:0] <= now_r);
  assign pop        = (state_r == ST_SCAN) && (count_r != '0) && expired;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    busy        = (state_r == ST_SCAN);
    chain       = '0;
    count_nxt   = count_r;
    now_nxt     = now_r;
    safe_nxt    = safe_r;
    dropped_nxt = dropped_r;
    ovalid_nxt  = 1'b0;
    osafe_nxt   = osafe_r;
    odrop_nxt   = odrop_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          chain.shift    = full;
          chain.load     = 1'b1;
          chain.load_idx = cnt_after_drop[IDX_W-1:0];
          count_nxt      = cnt_after_drop + CNT_W'(1);
          now_nxt        = in_now_ms;
          safe_nxt       = '0;
          dropped_nxt    = full;
        end
      end
      ST_SCAN: begin
        if (pop) begin
          chain.shift = 1'b1;
          count_nxt   = count_r - CNT_W'(1);
          safe_nxt    = head.ts;
        end else begin
          ovalid_nxt = 1'b1;
          osafe_nxt  = safe_r;
          odrop_nxt  = dropped_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      retention_r <= RETENTION_RESET;
      ovalid_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        retention_r <= cfg_retention_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    safe_r    <= safe_nxt;
    dropped_r <= dropped_nxt;
    osafe_r   <= osafe_nxt;
    odrop_r   <= odrop_nxt;
  end

  assign status.count       = count_r;
  assign out_valid          = ovalid_r;
  assign out_safe_point_ts  = osafe_r;
  assign out_collect        = (osafe_r != '0);
  assign out_sample_dropped = odrop_r;

endmodule

// ===== src/retention_safe_point_tracker.sv =====
// top level: sample cell chain and its scan sequencer
`timescale 1ns / 1ps
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+--------------------------
//  input    | in_now_ms, in_current_ts                      | start high, busy low
//  result   | out_collect, out_safe_point_ts,               | out_valid, one cycle,
//           | out_sample_dropped                            | no back-pressure
//  config   | cfg_retention_ms                              | cfg_we, no wait
//
//  after accept the scan retires the k samples that expire (0..FIFO_DEPTH) from the head,
//  then registers the result strobe once the head no longer expires
//  the rate is set by the head compare: one expiry check and chain shift per cycle
//  busy is high during the scan; the next item is taken in the cycle the strobe shows
//  synchronous active-low reset empties the chain and restores retention to 600000
//  the receiver cannot stall: each result is shown for exactly one cycle
//
module retention_safe_point_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rspt_pkg::TIME_W-1:0]   in_now_ms,
  input  logic [rspt_pkg::TS_W-1:0]     in_current_ts,
  output logic                          out_valid,
  output logic                          out_collect,
  output logic [rspt_pkg::TS_W-1:0]     out_safe_point_ts,
  output logic                          out_sample_dropped,
  input  logic                          cfg_we,
  input  logic [rspt_pkg::RET_W-1:0]    cfg_retention_ms
);
  import rspt_pkg::*;

  chain_ctrl_t  chain;
  ctrl_status_t status;
  sample_t      load_data;
  sample_t      cell_q [FIFO_DEPTH];
  sample_t      cell_next [FIFO_DEPTH];

  assign load_data.time_ms = in_now_ms;
  assign load_data.ts      = in_current_ts;

  // cell 0 is the oldest sample; the chain shifts toward it on pop or drop
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    logic load_en;

    assign load_en = chain.load && (chain.load_idx == IDX_W'(i));

    if (i == FIFO_DEPTH - 1) begin : g_last
      // nothing behind the tail cell, an empty slot shifts in
      assign cell_next[i] = '0;
    end else begin : g_mid
      assign cell_next[i] = cell_q[i+1];
    end

    rspt_cell u_cell (
      .clk       (clk),
      .shift     (chain.shift),
      .load      (load_en),
      .load_data (load_data),
      .neighbor  (cell_next[i]),
      .data      (cell_q[i])
    );
  end

  // sequencer sees only the head cell
  rspt_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .in_now_ms          (in_now_ms),
    .cfg_we             (cfg_we),
    .cfg_retention_ms   (cfg_retention_ms),
    .head               (cell_q[0]),
    .busy               (busy),
    .chain              (chain),
    .status             (status),
    .out_valid          (out_valid),
    .out_collect        (out_collect),
    .out_safe_point_ts  (out_safe_point_ts),
    .out_sample_dropped (out_sample_dropped)
  );

`ifndef SYNTHESIS
  // occupancy never exceeds the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.count <= CNT_W'(FIFO_DEPTH))
    else $error("sample count above chain depth");

  // a result only follows a scan cycle
  a_valid_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a scan");

  // a push always leaves at least one live sample before the scan
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (status.count != '0))
    else $error("push left the chain empty");

  // the chain never loads while scanning
  a_scan_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !chain.load)
    else $error("load during scan");
`endif

endmodule

// ===== test/rspt_safe_point_checker.sv =====
// checker for the retention safe point tracker: predicts each tick result and compares
`timescale 1ns / 1ps
module rspt_safe_point_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [rspt_pkg::TIME_W-1:0] in_now_ms,
  input  logic [rspt_pkg::TS_W-1:0]   in_current_ts,
  input  logic                        out_valid,
  input  logic                        out_collect,
  input  logic [rspt_pkg::TS_W-1:0]   out_safe_point_ts,
  input  logic                        out_sample_dropped,
  input  logic                        cfg_we,
  input  logic [rspt_pkg::RET_W-1:0]  cfg_retention_ms,
  output int                          mismatch_count,
  output int                          outstanding
);
  import rspt_pkg::*;

  typedef struct packed {
    logic            collect;
    logic [TS_W-1:0] safe_point_ts;
    logic            dropped;
  } tick_result_t;

  localparam int PEND_DEPTH = 8;

  logic [TIME_W-1:0] kept_time [FIFO_DEPTH];
  logic [TS_W-1:0]   kept_ts   [FIFO_DEPTH];
  logic [IDX_W-1:0]  oldest;
  int                live;
  logic [RET_W-1:0]  retention;
  // ring of predicted results waiting for their strobe
  tick_result_t      pending [PEND_DEPTH];
  logic [2:0]        pend_rd;
  logic [2:0]        pend_wr;
  int                pend_count;

  initial mismatch_count = 0;
  initial outstanding = 0;

  // push the new sample, dropping the oldest when full, then retire every aged sample from the head
  function automatic tick_result_t predict_tick(logic [TIME_W-1:0] now,
                                                logic [TS_W-1:0] ts);
    tick_result_t      r;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] expiry;
    logic [IDX_W-1:0]  tail;
    bit                scanning;
    r = '0;
    if (live >= FIFO_DEPTH) begin
      oldest = oldest + 1'b1;
      live = FIFO_DEPTH - 1;
      r.dropped = 1'b1;
    end
    tail = oldest + IDX_W'(live);
    kept_time[tail] = now;
    kept_ts[tail] = ts;
    live++;
    scanning = 1'b1;
    while (scanning && live > 0) begin
      sum = (TIME_W+1)'(kept_time[oldest]) + (TIME_W+1)'(retention);
      expiry = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
      if (expiry <= now) begin
        r.safe_point_ts = kept_ts[oldest];
        oldest = oldest + 1'b1;
        live--;
      end else begin
        scanning = 1'b0;
      end
    end
    r.collect = (r.safe_point_ts != '0);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    tick_result_t want;
    if (!rst_n) begin
      oldest = '0;
      live = 0;
      retention = RETENTION_RESET;
      pend_rd = '0;
      pend_wr = '0;
      pend_count = 0;
    end else begin
      // results first: an item may be taken in the same cycle as the strobe
      if (out_valid) begin
        if (pend_count == 0) begin
          $display("%0t unexpected result: expected none actual %b %h %b", $time,
                   out_collect, out_safe_point_ts, out_sample_dropped);
          mismatch_count++;
        end else begin
          want = pending[pend_rd];
          pend_rd = pend_rd + 1'b1;
          pend_count--;
          check_field("collect", 64'(want.collect), 64'(out_collect));
          check_field("safe_point_ts", want.safe_point_ts, out_safe_point_ts);
          check_field("sample_dropped", 64'(want.dropped), 64'(out_sample_dropped));
        end
      end
      if (start && !busy) begin
        pending[pend_wr] = predict_tick(in_now_ms, in_current_ts);
        pend_wr = pend_wr + 1'b1;
        pend_count++;
      end
      if (cfg_we) retention = cfg_retention_ms;
    end
    outstanding <= pend_count;
  end

endmodule

// ===== test/tb_retention_safe_point_tracker.sv =====
// testbench top for the retention safe point tracker: stimulus and verdict
`timescale 1ns / 1ps
module tb_retention_safe_point_tracker;
  import rspt_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic [TS_W-1:0]   in_current_ts = '0;
  logic              cfg_we = 1'b0;
  logic [RET_W-1:0]  cfg_retention_ms = RETENTION_RESET;
  logic              busy;
  logic              out_valid;
  logic              out_collect;
  logic [TS_W-1:0]   out_safe_point_ts;
  logic              out_sample_dropped;
  int                mismatch_count;
  int                outstanding;

  // stimulus state: a well-behaved wall clock and timestamp oracle
  logic [TIME_W-1:0] wall_ms;
  logic [TS_W-1:0]   oracle_ts;
  bit                no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  retention_safe_point_tracker uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_now_ms          (in_now_ms),
    .in_current_ts      (in_current_ts),
    .out_valid          (out_valid),
    .out_collect        (out_collect),
    .out_safe_point_ts  (out_safe_point_ts),
    .out_sample_dropped (out_sample_dropped),
    .cfg_we             (cfg_we),
    .cfg_retention_ms   (cfg_retention_ms)
  );

  rspt_safe_point_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_now_ms          (in_now_ms),
    .in_current_ts      (in_current_ts),
    .out_valid          (out_valid),
    .out_collect        (out_collect),
    .out_safe_point_ts  (out_safe_point_ts),
    .out_sample_dropped (out_sample_dropped),
    .cfg_we             (cfg_we),
    .cfg_retention_ms   (cfg_retention_ms),
    .mismatch_count     (mismatch_count),
    .outstanding        (outstanding)
  );

  // mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called in the same time step as the previous accept, so start gets one update
  task automatic send_tick(logic [TIME_W-1:0] now, logic [TS_W-1:0] ts);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_now_ms <= now;
    in_current_ts <= ts;
    // busy read right after the edge is the value the block sampled
    do @(posedge clk); while (busy);
  endtask

  // drop start and wait for every predicted result to come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_retention(logic [RET_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_retention_ms <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly a clock moving forward at a pace tied to the retention, with some
  // equal times, jumps past the retention, and wild or backwards times
  task automatic random_ticks(int count, logic [RET_W-1:0] ret);
    logic [TIME_W-1:0] now;
    logic [TS_W-1:0]   ts;
    int                p;
    wall_ms = {32'($urandom_range(0, 255)), 32'($urandom)};
    oracle_ts = {32'($urandom_range(0, 15)), 32'($urandom)};
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      p = $urandom_range(0, 99);
      if (p < 62) begin
        wall_ms = wall_ms + 64'($urandom_range(0, ret / 8 + 2));
        now = wall_ms;
      end else if (p < 77) begin
        wall_ms = wall_ms + 64'(ret) + 64'($urandom_range(0, 3));
        now = wall_ms;
      end else if (p < 91) begin
        now = wall_ms;
      end else if (p < 95) begin
        now = {32'($urandom), 32'($urandom)};
      end else if (p < 97) begin
        now = '1 - 64'($urandom_range(0, 31));
      end else begin
        now = 64'($urandom_range(0, 1000));
      end
      p = $urandom_range(0, 99);
      if (p < 80) begin
        oracle_ts = oracle_ts + 64'($urandom_range(1, 1000));
        ts = oracle_ts;
      end else if (p < 90) begin
        ts = {32'($urandom), 32'($urandom)};
      end else if (p < 95) begin
        ts = '0;
      end else begin
        ts = '1 - 64'($urandom_range(0, 3));
      end
      send_tick(now, ts);
    end
  endtask

  initial begin
    logic [RET_W-1:0] settings [8];
    no_idle = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset retention: the first sample ages out exactly at the boundary
    send_tick(64'd0, 64'd5);
    send_tick(64'd600000, 64'd7);
    send_tick(64'd600001, 64'd0);

    // zero retention: a time going backwards blocks, then everything retires,
    // then a zero timestamp sample expires on its own tick without collect
    set_retention('0);
    send_tick(64'd1000, '1);
    send_tick(64'd700000, 64'd9);
    send_tick(64'd800000, 64'd0);

    // full retention near the top of time: sums saturate, the fifo overflows
    // on the last push, then a tick at the maximum time retires all of it
    set_retention('1);
    for (int i = 0; i < 17; i++) send_tick('1 - 64'(40 - i), 64'(i + 1));
    send_tick('1, 64'hA5A5_5A5A_0F0F_F0F0);

    settings[0] = 32'd1;
    settings[1] = '0;
    settings[2] = 32'd10;
    settings[3] = RETENTION_RESET;
    settings[4] = '1;
    settings[5] = $urandom;
    settings[6] = $urandom_range(2, 5000);
    settings[7] = 32'd64;
    foreach (settings[k]) begin
      set_retention(settings[k]);
      random_ticks(160, settings[k]);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS retention_safe_point_tracker");
    end else begin
      $display("FAIL retention_safe_point_tracker");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #4000000;
    $display("FAIL retention_safe_point_tracker");
    $finish;
  end

endmodule
